// ----- sv/ile_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ile_pkg
// Shared request modes, status codes and cell control type for the list engine.
// ----------------------------------------------------------------------------
package ile_pkg;

    localparam int MODE_W   = 3;
    localparam int POS_W    = 7;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 7;

    localparam logic [MODE_W-1:0] MODE_READ = 3'd0;
    localparam logic [MODE_W-1:0] MODE_HEAD = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TAIL = 3'd2;
    localparam logic [MODE_W-1:0] MODE_AT   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DEL  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // broadcast to every cell in the chain
    typedef struct packed {
        logic ins;  // open a slot at the target and load the new value
        logic del;  // close the slot at the target
    } t_cell_ctl;

endpackage

// ----- sv/ile_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ile request / response interfaces
// Valid/ready channels carrying list requests and their results.
// ----------------------------------------------------------------------------
interface ile_req_if import ile_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic        [MODE_W-1:0] mode;
    logic        [POS_W-1:0]  position;
    logic signed [DATA_W-1:0] item_value;

    modport source (output valid, mode, position, item_value, input ready);
    modport sink   (input valid, mode, position, item_value, output ready);
endinterface

interface ile_rsp_if import ile_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [DATA_W-1:0]   read_value;
    logic        [STATUS_W-1:0] status;
    logic        [LEN_W-1:0]    length;

    modport source (output valid, read_value, status, length, input ready);
    modport sink   (input valid, read_value, status, length, output ready);
endinterface

// ----- sv/indexed_list_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_engine
// Ordered list of up to DEPTH signed 32-bit values in a chain of shift cells.
// ----------------------------------------------------------------------------
// Usage:
//  - i_req carries one request per transaction: mode (read, insert head,
//    insert tail, insert at position, delete at position), position, value.
//  - o_rsp returns exactly one transaction per request: read_value (-1 unless
//    an in-range read), status (done / out of range / full) and the length
//    after the request.
//  - Latency: the result is registered and appears the cycle after the
//    request is accepted. Throughput: one request per cycle unless o_rsp
//    stalls; every cell compares its own index with the target and shifts
//    from its neighbor, so any insert, delete or read ends in its accept cycle.
//  - The response register is a single stage: while o_rsp is stalled,
//    i_req.ready is low; it rises again in the cycle the result is taken.
//  - Reset empties the list (length 0) and drops any pending result. Cell
//    contents are not cleared; slots past the length are never read.
//  - Unused mode codes change nothing and report done with -1.
// ----------------------------------------------------------------------------
module indexed_list_engine import ile_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ile_req_if.sink       i_req,
    ile_rsp_if.source     o_rsp
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;  // cell index width
    localparam int CW = $clog2(DEPTH + 1);                // count width
    localparam int AW = (CW > POS_W) ? CW : POS_W;        // compare width
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    // list length
    logic [CW-1:0] r_count, n_count;

    // response register
    logic                       r_vld;
    logic signed [DATA_W-1:0]   r_read_value, n_read_value;
    logic        [STATUS_W-1:0] r_status, n_status;
    logic        [LEN_W-1:0]    r_length;

    logic          accept;
    logic [AW-1:0] pos_ext;
    logic [AW-1:0] cnt_ext;
    logic [AW-1:0] nxt_ext;
    logic          full;
    logic          ins_ok;
    logic          del_ok;
    logic [IW-1:0] tgt;
    t_cell_ctl     ctl;

    logic signed [DATA_W-1:0] cell_val [DEPTH];
    logic signed [DATA_W-1:0] cell_rd  [DEPTH];
    logic signed [DATA_W-1:0] rd_bus;

    assign i_req.ready = !r_vld || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;

    assign pos_ext = AW'(i_req.position);
    assign cnt_ext = AW'(r_count);
    assign full    = (r_count == FULL_CNT);

    // decode the request against the current length
    always_comb begin
        n_status     = ST_DONE;
        n_read_value = '1;
        ins_ok       = 1'b0;
        del_ok       = 1'b0;
        tgt          = pos_ext[IW-1:0];
        n_count      = r_count;
        unique case (i_req.mode)
            MODE_READ: begin
                if (pos_ext < cnt_ext) begin
                    n_read_value = rd_bus;
                end else begin
                    n_status = ST_RANGE;
                end
            end
            MODE_HEAD: begin
                tgt = '0;
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    ins_ok = 1'b1;
                end
            end
            MODE_TAIL: begin
                tgt = r_count[IW-1:0];
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    ins_ok = 1'b1;
                end
            end
            MODE_AT: begin
                if (pos_ext > cnt_ext) begin
                    n_status = ST_RANGE;
                end else if (full) begin
                    n_status = ST_FULL;
                end else begin
                    ins_ok = 1'b1;
                end
            end
            MODE_DEL: begin
                if (pos_ext < cnt_ext) begin
                    del_ok = 1'b1;
                end else begin
                    n_status = ST_RANGE;
                end
            end
            default: begin
            end
        endcase
        if (ins_ok) begin
            n_count = r_count + 1'b1;
        end else if (del_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    assign ctl.ins = accept && ins_ok;
    assign ctl.del = accept && del_ok;
    assign nxt_ext = AW'(n_count);

    // chain of cells; ends are tied off
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic signed [DATA_W-1:0] left_val;
            logic signed [DATA_W-1:0] right_val;
            if (g == 0) begin : g_first
                assign left_val = '0;
            end else begin : g_mid_l
                assign left_val = cell_val[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign right_val = '0;
            end else begin : g_mid_r
                assign right_val = cell_val[g+1];
            end
            ile_cell #(
                .IW  (IW),
                .IDX (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (ctl),
                .i_pos   (tgt),
                .i_value (i_req.item_value),
                .i_left  (left_val),
                .i_right (right_val),
                .o_value (cell_val[g]),
                .o_rd    (cell_rd[g])
            );
        end
    endgenerate

    // only the matching cell drives a nonzero value
    always_comb begin
        rd_bus = '0;
        for (int k = 0; k < DEPTH; k++) begin
            rd_bus = rd_bus | cell_rd[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_vld   <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= n_count;
                r_vld   <= 1'b1;
            end else if (o_rsp.ready) begin
                r_vld   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_read_value <= n_read_value;
            r_status     <= n_status;
            r_length     <= nxt_ext[LEN_W-1:0];
        end
    end

    assign o_rsp.valid      = r_vld;
    assign o_rsp.read_value = r_read_value;
    assign o_rsp.status     = r_status;
    assign o_rsp.length     = r_length;

endmodule

// ----- sv/ile_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ile_cell
// One list slot: holds a value, shifts from a neighbor on insert or delete.
// ----------------------------------------------------------------------------
module ile_cell import ile_pkg::*; #(
    parameter int IW  = 6,
    parameter int IDX = 0
) (
    input  logic                     i_clk,
    input  t_cell_ctl                i_ctl,
    input  logic        [IW-1:0]     i_pos,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic signed [DATA_W-1:0] i_left,
    input  logic signed [DATA_W-1:0] i_right,
    output logic signed [DATA_W-1:0] o_value,
    output logic signed [DATA_W-1:0] o_rd
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic signed [DATA_W-1:0] r_val;
    logic                     hit;
    logic                     above;

    assign hit   = (i_pos == MY_IDX);
    assign above = (MY_IDX > i_pos);

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            if (above) begin
                r_val <= i_left;
            end else if (hit) begin
                r_val <= i_value;
            end
        end else if (i_ctl.del) begin
            if (above || hit) begin
                r_val <= i_right;
            end
        end
    end

    assign o_value = r_val;
    // gated for the OR-reduced read bus
    assign o_rd    = hit ? r_val : '0;

endmodule
